[hw/rtl/lpfr_pkg.sv]
package lpfr_pkg;

  typedef logic [7:0] byte_t;

  // input item kind
  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  // result kind
  localparam logic KindByte  = 1'b0;
  localparam logic KindError = 1'b1;

  localparam byte_t IdleTimeoutReset = 8'd30;
  localparam byte_t IdleCountMax     = 8'hff;

endpackage

[hw/rtl/lpfr_ram.sv]
module lpfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/length_prefixed_frame_receiver.sv]
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-------------------------------
// in       | sink      | in_valid_i / in_stall_o  | mode_i, rx_byte_i
// out      | source    | out_valid_o / out_stall_i| kind_o, frame_byte_o, last_o
// cfg      | sink      | cfg_valid_i / cfg_ready_o| cfg_data_i (idle timeout ticks)
//
// a byte or tick request is taken while no frame is being sent and the output is not stalled
// a completed frame of N bytes is sent from the frame memory byte by byte, each byte
//   read from memory and then loaded into the output register, input stalled meanwhile
// stalls on the output channel stretch the read cycle and hold the input
// reset clears the frame count, idle count and timeout (back to 30 ticks);
//   frame memory contents are not cleared
module length_prefixed_frame_receiver #(
  parameter int MaxFrame = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input requests
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  lpfr_pkg::byte_t rx_byte_i,
  // result requests
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output lpfr_pkg::byte_t frame_byte_o,
  output logic            last_o,
  // configuration write
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  lpfr_pkg::byte_t cfg_data_i
);

  import lpfr_pkg::*;

  localparam int AddrW  = $clog2(MaxFrame);
  localparam int CountW = $clog2(MaxFrame + 1);

  typedef enum logic [1:0] {
    StIdle,   // taking bytes and ticks
    StRead,   // read one stored byte when the output register frees up
    StLoad    // move the read data into the output register
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   held_q, held_d;     // bytes of the partial frame, 0 = no frame
  logic [CountW-1:0]   len_q, len_d;       // copy of the length prefix
  byte_t               idle_q, idle_d;     // ticks since the last byte
  byte_t               timeout_q, timeout_d;
  logic [AddrW-1:0]    rd_addr_q, rd_addr_d;
  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  byte_t               byte_q, byte_d;
  logic                last_q, last_d;

  logic                in_take;
  logic                out_free;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic                mem_re;
  byte_t               mem_rdata;
  byte_t               idle_inc;
  logic [CountW-1:0]   held_inc;
  logic                bad_len;

  // output register is free at the next edge if empty or being taken now
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  assign idle_inc = (idle_q == IdleCountMax) ? idle_q : idle_q + 8'd1;
  assign held_inc = held_q + CountW'(1);
  assign bad_len  = (rx_byte_i == 8'd0) || (rx_byte_i > 8'(MaxFrame));

  // every accepted byte that opens or extends a frame lands in memory
  assign mem_we    = in_take && (mode_i == ModeByte) && ((held_q != '0) || !bad_len);
  assign mem_waddr = held_q[AddrW-1:0];
  assign mem_re    = (state_q == StRead) && out_free;

  lpfr_ram #(
    .Width (8),
    .Depth (MaxFrame)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    len_d       = len_q;
    idle_d      = idle_q;
    timeout_d   = timeout_q;
    rd_addr_d   = rd_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    last_d      = last_q;

    if (cfg_valid_i && cfg_ready_o) begin
      timeout_d = cfg_data_i;
    end

    case (state_q)
      StIdle: begin
        if (in_take) begin
          if (mode_i == ModeTick) begin
            // ticks only count while a frame is open
            if (held_q != '0) begin
              if (idle_inc >= timeout_q) begin
                held_d      = '0;
                idle_d      = '0;
                out_valid_d = 1'b1;
                kind_d      = KindError;
                byte_d      = '0;
                last_d      = 1'b1;
              end else begin
                idle_d = idle_inc;
              end
            end
          end else begin
            idle_d = '0;
            if (held_q == '0) begin
              if (bad_len) begin
                out_valid_d = 1'b1;
                kind_d      = KindError;
                byte_d      = '0;
                last_d      = 1'b1;
              end else begin
                len_d = CountW'(rx_byte_i);
                if (rx_byte_i == 8'd1) begin
                  // single byte frame is complete at once
                  held_d    = '0;
                  rd_addr_d = '0;
                  state_d   = StRead;
                end else begin
                  held_d = CountW'(1);
                end
              end
            end else if (held_inc >= len_q) begin
              held_d    = '0;
              rd_addr_d = '0;
              state_d   = StRead;
            end else begin
              held_d = held_inc;
            end
          end
        end
      end
      StRead: begin
        if (out_free) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        out_valid_d = 1'b1;
        kind_d      = KindByte;
        byte_d      = mem_rdata;
        last_d      = (CountW'(rd_addr_q) + CountW'(1)) == len_q;
        if (last_d) begin
          state_d = StIdle;
        end else begin
          rd_addr_d = rd_addr_q + AddrW'(1);
          state_d   = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      held_q      <= '0;
      len_q       <= '0;
      idle_q      <= '0;
      timeout_q   <= IdleTimeoutReset;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KindByte;
      byte_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      len_q       <= len_d;
      idle_q      <= idle_d;
      timeout_q   <= timeout_d;
      rd_addr_q   <= rd_addr_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      byte_q      <= byte_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign frame_byte_o = byte_q;
  assign last_o       = last_q;

  // an open frame never holds its full length
  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != '0 |-> held_q < len_q)
    else $error("partial frame count reached its length");

  // idle time only accrues on an open frame
  a_idle_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q != '0 |-> held_q != '0)
    else $error("idle count running without a frame");

  // the load cycle always finds the output register empty
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> !out_valid_q)
    else $error("output register overwritten");

  // no input is taken while a frame is being sent
  a_no_take_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_take && !mem_we)
    else $error("input taken during frame emission");

  // a read is always followed by its load
  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> state_q == StLoad)
    else $error("memory read without load");

endmodule
